@@ design/rv32ic_pkg.sv @@
package rv32ic_pkg;

    typedef enum logic [5:0] {
        MN_UNKNOWN = 6'd0,
        MN_LB = 6'd1, MN_LH = 6'd2, MN_LW = 6'd3, MN_LBU = 6'd4, MN_LHU = 6'd5,
        MN_ADDI = 6'd6, MN_SLLI = 6'd7, MN_SLTI = 6'd8, MN_SLTIU = 6'd9,
        MN_XORI = 6'd10, MN_SRLI = 6'd11, MN_SRAI = 6'd12, MN_ORI = 6'd13,
        MN_ANDI = 6'd14, MN_AUIPC = 6'd15, MN_SB = 6'd16, MN_SH = 6'd17,
        MN_SW = 6'd18, MN_ADD = 6'd19, MN_SUB = 6'd20, MN_SLL = 6'd21,
        MN_SLT = 6'd22, MN_SLTU = 6'd23, MN_XOR = 6'd24, MN_SRL = 6'd25,
        MN_SRA = 6'd26, MN_OR = 6'd27, MN_AND = 6'd28, MN_LUI = 6'd29,
        MN_BEQ = 6'd30, MN_BNE = 6'd31, MN_BLT = 6'd32, MN_BGE = 6'd33,
        MN_BLTU = 6'd34, MN_BGEU = 6'd35, MN_JALR = 6'd36, MN_JAL = 6'd37,
        MN_ECALL = 6'd38
    } mnemonic_t;

    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    typedef struct packed {
        mnemonic_t   mn;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [31:0] imm;
        logic        tgt;
    } dec_t;

endpackage

@@ design/rv32ic_decode.sv @@
module rv32ic_decode (
    input  logic [31:0]       w,
    output rv32ic_pkg::dec_t  d
);
    import rv32ic_pkg::*;

    dec_t d32, d16;
    logic [6:0]  op, f7;
    logic [2:0]  f3, cf3;
    logic [4:0]  rd, rs1, rs2, r, r2, rp, rp2;
    logic [31:0] ii, si, bi, ji, ci, lsi, cji, cbi, swi;

    assign op  = w[6:0];
    assign rd  = w[11:7];
    assign f3  = w[14:12];
    assign rs1 = w[19:15];
    assign rs2 = w[24:20];
    assign f7  = w[31:25];
    assign ii  = {{20{w[31]}}, w[31:20]};
    assign si  = {{20{w[31]}}, w[31:25], w[11:7]};
    assign bi  = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
    assign ji  = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};

    assign cf3 = w[15:13];
    assign r   = w[11:7];
    assign r2  = w[6:2];
    assign rp  = {2'b01, w[9:7]};
    assign rp2 = {2'b01, w[4:2]};
    assign ci  = {{26{w[12]}}, w[12], w[6:2]};
    assign lsi = {25'd0, w[5], w[12:10], w[6], 2'b00};
    assign cji = {{21{w[12]}}, w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
    assign cbi = {{24{w[12]}}, w[6:5], w[2], w[11:10], w[4:3], 1'b0};
    assign swi = {24'd0, w[8:7], w[12:9], 2'b00};

    // 32-bit forms
    always_comb
    begin
        d32 = '0;
        case (op)
            OP_LOAD:
            begin
                case (f3)
                    3'd0: d32.mn = MN_LB;
                    3'd1: d32.mn = MN_LH;
                    3'd2: d32.mn = MN_LW;
                    3'd4: d32.mn = MN_LBU;
                    3'd5: d32.mn = MN_LHU;
                    default: d32.mn = MN_UNKNOWN;
                endcase
                d32.rd = rd; d32.ra = rs1; d32.imm = ii;
            end
            OP_IMM:
            begin
                case (f3)
                    3'd0: d32.mn = MN_ADDI;
                    3'd1: d32.mn = MN_SLLI;
                    3'd2: d32.mn = MN_SLTI;
                    3'd3: d32.mn = MN_SLTIU;
                    3'd4: d32.mn = MN_XORI;
                    3'd5: d32.mn = (f7 == 7'd0) ? MN_SRLI : MN_SRAI;
                    3'd6: d32.mn = MN_ORI;
                    default: d32.mn = MN_ANDI;
                endcase
                d32.rd = rd; d32.ra = rs1; d32.imm = ii;
            end
            OP_REG:
            begin
                case (f3)
                    3'd0: d32.mn = (f7 == 7'h20) ? MN_SUB : MN_ADD;
                    3'd1: d32.mn = MN_SLL;
                    3'd2: d32.mn = MN_SLT;
                    3'd3: d32.mn = MN_SLTU;
                    3'd4: d32.mn = MN_XOR;
                    3'd5: d32.mn = (f7 == 7'h20) ? MN_SRA : MN_SRL;
                    3'd6: d32.mn = MN_OR;
                    default: d32.mn = MN_AND;
                endcase
                d32.rd = rd; d32.ra = rs1; d32.rb = rs2;
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0: d32.mn = MN_BEQ;
                    3'd1: d32.mn = MN_BNE;
                    3'd4: d32.mn = MN_BLT;
                    3'd5: d32.mn = MN_BGE;
                    3'd6: d32.mn = MN_BLTU;
                    3'd7: d32.mn = MN_BGEU;
                    default: d32.mn = MN_UNKNOWN;
                endcase
                d32.ra = rs1; d32.rb = rs2; d32.imm = bi; d32.tgt = 1'b1;
            end
            OP_LUI:
            begin
                d32.mn = MN_LUI; d32.rd = rd; d32.imm = {w[31:12], 12'd0};
            end
            OP_AUIPC:
            begin
                d32.mn = MN_AUIPC; d32.rd = rd; d32.imm = {w[31:12], 12'd0};
            end
            OP_STORE:
            begin
                case (f3)
                    3'd0: d32.mn = MN_SB;
                    3'd1: d32.mn = MN_SH;
                    3'd2: d32.mn = MN_SW;
                    default: d32.mn = MN_UNKNOWN;
                endcase
                d32.ra = rs1; d32.rb = rs2; d32.imm = si;
            end
            OP_JALR:
            begin
                d32.mn = MN_JALR; d32.rd = rd; d32.ra = rs1; d32.imm = ii;
            end
            OP_JAL:
            begin
                d32.mn = MN_JAL; d32.rd = rd; d32.imm = ji; d32.tgt = 1'b1;
            end
            OP_SYSTEM: d32.mn = MN_ECALL;
            default: d32 = '0;
        endcase
    end

    // 16-bit forms, expanded to base operations
    always_comb
    begin
        d16 = '0;
        case (w[1:0])
            2'd0:
            begin
                if (cf3 == 3'd2)
                begin
                    d16.mn = MN_LW; d16.rd = rp2; d16.ra = rp; d16.imm = lsi;
                end
                else if (cf3 == 3'd6)
                begin
                    d16.mn = MN_SW; d16.ra = rp; d16.rb = rp2; d16.imm = lsi;
                end
            end
            2'd1:
            begin
                case (cf3)
                    3'd0:
                    begin
                        d16.mn = MN_ADDI; d16.rd = r; d16.ra = r; d16.imm = ci;
                    end
                    3'd1:
                    begin
                        d16.mn = MN_JAL; d16.rd = 5'd1; d16.imm = cji; d16.tgt = 1'b1;
                    end
                    3'd2:
                    begin
                        d16.mn = MN_ADDI; d16.rd = r; d16.imm = ci;
                    end
                    3'd3:
                    begin
                        d16.mn = MN_LUI; d16.rd = r; d16.imm = {ci[19:0], 12'd0};
                    end
                    3'd4:
                    begin
                        d16.rd = rp; d16.ra = rp;
                        case (w[11:10])
                            2'd0: begin d16.mn = MN_SRLI; d16.imm = ci; end
                            2'd1: begin d16.mn = MN_SRAI; d16.imm = ci; end
                            2'd2: begin d16.mn = MN_ANDI; d16.imm = ci; end
                            default:
                            begin
                                d16.rb = rp2;
                                case (w[6:5])
                                    2'd0: d16.mn = MN_SUB;
                                    2'd1: d16.mn = MN_XOR;
                                    2'd2: d16.mn = MN_OR;
                                    default: d16.mn = MN_AND;
                                endcase
                            end
                        endcase
                    end
                    3'd5:
                    begin
                        d16.mn = MN_JAL; d16.imm = cji; d16.tgt = 1'b1;
                    end
                    3'd6:
                    begin
                        d16.mn = MN_BEQ; d16.ra = rp; d16.imm = cbi; d16.tgt = 1'b1;
                    end
                    default:
                    begin
                        d16.mn = MN_BNE; d16.ra = rp; d16.imm = cbi; d16.tgt = 1'b1;
                    end
                endcase
            end
            default:
            begin
                if (cf3 == 3'd0)
                begin
                    d16.mn = MN_SLLI; d16.rd = r; d16.ra = r; d16.imm = ci;
                end
                else if (cf3 == 3'd4)
                begin
                    if (!w[12])
                    begin
                        if (r2 == 5'd0)
                        begin
                            d16.mn = MN_JALR; d16.ra = r;
                        end
                        else
                        begin
                            d16.mn = MN_ADDI; d16.rd = r; d16.ra = r2;
                        end
                    end
                    else if (r2 == 5'd0)
                    begin
                        d16.mn = MN_JALR; d16.rd = 5'd1; d16.ra = r;
                    end
                    else
                    begin
                        d16.mn = MN_ADD; d16.rd = r; d16.ra = r; d16.rb = r2;
                    end
                end
                else if (cf3 == 3'd6)
                begin
                    d16.mn = MN_SW; d16.ra = 5'd2; d16.rb = r2; d16.imm = swi;
                end
            end
        endcase
    end

    // unknown codes report all zero
    always_comb
    begin
        d = (w[1:0] == 2'b11) ? d32 : d16;
        if (d.mn == MN_UNKNOWN)
            d = '0;
    end

endmodule

@@ design/rv32ic_instruction_decoder_core.sv @@
// channel | signals                          | direction
// fetch   | in_valid/in_ready, fetch_word    | in
// decode  | out_valid/out_ready, result set  | out
// One word per cycle while the output is not stalled: decode is a single pass from the input register to the
// output register; the kept pc adds 2 or 4 in the same pass.
// Result valid is raised when the word moves from the input register into the output register.
// Reset clears the pc to 0 and both valid flags.
// A stalled output holds; the input register fills behind it, then ready drops.
module rv32ic_instruction_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] fetch_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] instr_addr,
    output logic        is_compressed,
    output logic [5:0]  mnemonic,
    output logic [4:0]  dest_reg,
    output logic [4:0]  src_reg_a,
    output logic [4:0]  src_reg_b,
    output logic signed [31:0] immediate,
    output logic [31:0] jump_target,
    output logic        has_target
);
    import rv32ic_pkg::*;

    logic        iv_reg;
    logic [31:0] word_reg;
    logic [31:0] pc_reg, pc_next;
    logic        ov_reg;
    dec_t        dec, dec_reg;
    logic [31:0] addr_reg;
    logic        comp_reg;
    logic        advance;

    assign advance  = iv_reg && (!ov_reg || out_ready);
    assign in_ready = !iv_reg || advance;

    rv32ic_decode u_dec (.w(word_reg), .d(dec));

    assign pc_next = pc_reg + ((word_reg[1:0] == 2'b11) ? 32'd4 : 32'd2);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
            ov_reg <= 1'b0;
            pc_reg <= '0;
        end
        else
        begin
            if (in_ready)
                iv_reg <= in_valid;
            if (advance)
            begin
                ov_reg <= 1'b1;
                pc_reg <= pc_next;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= fetch_word;
        if (advance)
        begin
            dec_reg  <= dec;
            addr_reg <= pc_reg;
            comp_reg <= (word_reg[1:0] != 2'b11);
        end
    end

    assign out_valid     = ov_reg;
    assign instr_addr    = addr_reg;
    assign is_compressed = comp_reg;
    assign mnemonic      = dec_reg.mn;
    assign dest_reg      = dec_reg.rd;
    assign src_reg_a     = dec_reg.ra;
    assign src_reg_b     = dec_reg.rb;
    assign immediate     = dec_reg.imm;
    assign jump_target   = dec_reg.tgt ? (addr_reg + dec_reg.imm) : 32'd0;
    assign has_target    = dec_reg.tgt;

endmodule

@@ tb/tb_rv32ic_instruction_decoder_core.sv @@
module tb_rv32ic_instruction_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rv32ic_pkg::*;

    typedef struct packed {
        logic [31:0] addr;
        logic        comp;
        logic [5:0]  mn;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [31:0] imm;
        logic [31:0] target;
        logic        tgt;
    } decoded_t;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] fetch_word;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] instr_addr;
    logic        is_compressed;
    logic [5:0]  mnemonic;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic signed [31:0] immediate;
    logic [31:0] jump_target;
    logic        has_target;

    logic [31:0] word_queue[$];
    decoded_t    decode_queue[$];
    logic [31:0] pred_pc = '0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    rv32ic_instruction_decoder_core DUT (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [31:0] sext(input logic [31:0] v, input int bits);
        logic [31:0] m;
        m = (32'd1 << bits) - 32'd1;
        v = v & m;
        if (v[bits-1])
            v = v | ~m;
        return v;
    endfunction

    // 32-bit base forms
    function automatic void decode_base(input logic [31:0] w, inout decoded_t d);
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] ii, si, bi, ji;
        mnemonic_t   m;
        f3 = w[14:12];
        f7 = w[31:25];
        ii = sext(32'(w[31:20]), 12);
        si = sext(32'({w[31:25], w[11:7]}), 12);
        bi = sext(32'({w[31], w[7], w[30:25], w[11:8], 1'b0}), 13);
        ji = sext(32'({w[31], w[19:12], w[20], w[30:21], 1'b0}), 21);
        m = MN_UNKNOWN;
        case (w[6:0])
            OP_LOAD:
            begin
                case (f3)
                    3'd0: m = MN_LB;
                    3'd1: m = MN_LH;
                    3'd2: m = MN_LW;
                    3'd4: m = MN_LBU;
                    3'd5: m = MN_LHU;
                    default: m = MN_UNKNOWN;
                endcase
                d.rd = w[11:7]; d.ra = w[19:15]; d.imm = ii;
            end
            OP_IMM:
            begin
                case (f3)
                    3'd0: m = MN_ADDI;
                    3'd1: m = MN_SLLI;
                    3'd2: m = MN_SLTI;
                    3'd3: m = MN_SLTIU;
                    3'd4: m = MN_XORI;
                    3'd5: m = (f7 == 7'd0) ? MN_SRLI : MN_SRAI;
                    3'd6: m = MN_ORI;
                    default: m = MN_ANDI;
                endcase
                d.rd = w[11:7]; d.ra = w[19:15]; d.imm = ii;
            end
            OP_REG:
            begin
                case (f3)
                    3'd0: m = (f7 == 7'h20) ? MN_SUB : MN_ADD;
                    3'd1: m = MN_SLL;
                    3'd2: m = MN_SLT;
                    3'd3: m = MN_SLTU;
                    3'd4: m = MN_XOR;
                    3'd5: m = (f7 == 7'h20) ? MN_SRA : MN_SRL;
                    3'd6: m = MN_OR;
                    default: m = MN_AND;
                endcase
                d.rd = w[11:7]; d.ra = w[19:15]; d.rb = w[24:20];
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0: m = MN_BEQ;
                    3'd1: m = MN_BNE;
                    3'd4: m = MN_BLT;
                    3'd5: m = MN_BGE;
                    3'd6: m = MN_BLTU;
                    3'd7: m = MN_BGEU;
                    default: m = MN_UNKNOWN;
                endcase
                d.ra = w[19:15]; d.rb = w[24:20]; d.imm = bi; d.tgt = 1'b1;
            end
            OP_LUI:
            begin
                m = MN_LUI; d.rd = w[11:7]; d.imm = {w[31:12], 12'd0};
            end
            OP_AUIPC:
            begin
                m = MN_AUIPC; d.rd = w[11:7]; d.imm = {w[31:12], 12'd0};
            end
            OP_STORE:
            begin
                case (f3)
                    3'd0: m = MN_SB;
                    3'd1: m = MN_SH;
                    3'd2: m = MN_SW;
                    default: m = MN_UNKNOWN;
                endcase
                d.ra = w[19:15]; d.rb = w[24:20]; d.imm = si;
            end
            OP_JALR:
            begin
                m = MN_JALR; d.rd = w[11:7]; d.ra = w[19:15]; d.imm = ii;
            end
            OP_JAL:
            begin
                m = MN_JAL; d.rd = w[11:7]; d.imm = ji; d.tgt = 1'b1;
            end
            OP_SYSTEM: m = MN_ECALL;
            default: m = MN_UNKNOWN;
        endcase
        d.mn = m;
    endfunction

    // 16-bit compressed forms, expanded to base mnemonics
    function automatic void decode_comp(input logic [15:0] w, inout decoded_t d);
        logic [2:0]  f3;
        logic [4:0]  r, r2, rp, rp2;
        logic [31:0] ci, lsi, ji, bi;
        mnemonic_t   m;
        f3 = w[15:13];
        r = w[11:7];
        r2 = w[6:2];
        rp = {2'b01, w[9:7]};
        rp2 = {2'b01, w[4:2]};
        ci = sext(32'({w[12], w[6:2]}), 6);
        lsi = {25'd0, w[5], w[12:10], w[6], 2'd0};
        ji = sext(32'({w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0}), 12);
        bi = sext(32'({w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0}), 9);
        m = MN_UNKNOWN;
        case (w[1:0])
            2'd0:
            begin
                if (f3 == 3'd2)
                begin
                    m = MN_LW; d.rd = rp2; d.ra = rp; d.imm = lsi;
                end
                else if (f3 == 3'd6)
                begin
                    m = MN_SW; d.ra = rp; d.rb = rp2; d.imm = lsi;
                end
            end
            2'd1:
            begin
                case (f3)
                    3'd0: begin m = MN_ADDI; d.rd = r; d.ra = r; d.imm = ci; end
                    3'd1: begin m = MN_JAL; d.rd = 5'd1; d.imm = ji; d.tgt = 1'b1; end
                    3'd2: begin m = MN_ADDI; d.rd = r; d.imm = ci; end
                    3'd3: begin m = MN_LUI; d.rd = r; d.imm = ci << 12; end
                    3'd4:
                    begin
                        d.rd = rp; d.ra = rp;
                        case (w[11:10])
                            2'd0: begin m = MN_SRLI; d.imm = ci; end
                            2'd1: begin m = MN_SRAI; d.imm = ci; end
                            2'd2: begin m = MN_ANDI; d.imm = ci; end
                            default:
                            begin
                                d.rb = rp2;
                                case (w[6:5])
                                    2'd0: m = MN_SUB;
                                    2'd1: m = MN_XOR;
                                    2'd2: m = MN_OR;
                                    default: m = MN_AND;
                                endcase
                            end
                        endcase
                    end
                    3'd5: begin m = MN_JAL; d.imm = ji; d.tgt = 1'b1; end
                    3'd6: begin m = MN_BEQ; d.ra = rp; d.imm = bi; d.tgt = 1'b1; end
                    default: begin m = MN_BNE; d.ra = rp; d.imm = bi; d.tgt = 1'b1; end
                endcase
            end
            default:
            begin
                if (f3 == 3'd0)
                begin
                    m = MN_SLLI; d.rd = r; d.ra = r; d.imm = ci;
                end
                else if (f3 == 3'd4)
                begin
                    if (!w[12])
                    begin
                        if (r2 == 5'd0) begin m = MN_JALR; d.ra = r; end
                        else begin m = MN_ADDI; d.rd = r; d.ra = r2; end
                    end
                    else
                    begin
                        if (r2 == 5'd0) begin m = MN_JALR; d.rd = 5'd1; d.ra = r; end
                        else begin m = MN_ADD; d.rd = r; d.ra = r; d.rb = r2; end
                    end
                end
                else if (f3 == 3'd6)
                begin
                    m = MN_SW; d.ra = 5'd2; d.rb = r2;
                    d.imm = {24'd0, w[8:7], w[12:9], 2'd0};
                end
            end
        endcase
        d.mn = m;
    endfunction

    // expected result for one word; advances the predicted pc
    function automatic decoded_t predict_decode(input logic [31:0] w);
        decoded_t d;
        d = '0;
        d.comp = (w[1:0] != 2'b11);
        if (d.comp)
            decode_comp(w[15:0], d);
        else
            decode_base(w, d);
        if (d.mn == MN_UNKNOWN)
            d = '{default: '0, comp: d.comp};
        d.addr = pred_pc;
        d.target = d.tgt ? pred_pc + d.imm : 32'd0;
        pred_pc = pred_pc + (d.comp ? 32'd2 : 32'd4);
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s at addr %h: got %h expected %h", what, instr_addr, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            fetch_word <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                fetch_word <= word_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // accepted words become expectations
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            decode_queue.push_back(predict_decode(fetch_word));
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        decoded_t e;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decode_queue.size() == 0)
                begin
                    $display("MISMATCH unexpected word at addr %h", instr_addr);
                    error_count++;
                end
                else
                begin
                    e = decode_queue.pop_front();
                    if (instr_addr !== e.addr) report_mismatch("instr_addr", instr_addr, e.addr);
                    if (is_compressed !== e.comp)
                        report_mismatch("is_compressed", 32'(is_compressed), 32'(e.comp));
                    if (mnemonic !== e.mn)
                        report_mismatch("mnemonic", 32'(mnemonic), 32'(e.mn));
                    if (dest_reg !== e.rd)
                        report_mismatch("dest_reg", 32'(dest_reg), 32'(e.rd));
                    if (src_reg_a !== e.ra)
                        report_mismatch("src_reg_a", 32'(src_reg_a), 32'(e.ra));
                    if (src_reg_b !== e.rb)
                        report_mismatch("src_reg_b", 32'(src_reg_b), 32'(e.rb));
                    if (immediate !== e.imm) report_mismatch("immediate", immediate, e.imm);
                    if (jump_target !== e.target)
                        report_mismatch("jump_target", jump_target, e.target);
                    if (has_target !== e.tgt)
                        report_mismatch("has_target", 32'(has_target), 32'(e.tgt));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [31:0] random_base();
        logic [31:0] w;
        logic [6:0]  ops[10];
        ops = '{OP_LOAD, OP_IMM, OP_REG, OP_BRANCH, OP_LUI, OP_AUIPC,
                OP_STORE, OP_JALR, OP_JAL, OP_SYSTEM};
        w = $urandom();
        if ($urandom_range(9) != 0)
            w[6:0] = ops[$urandom_range(9)];
        else
            w[1:0] = 2'b11;
        // favor the funct7 values that pick SUB/SRA/SRLI
        if ($urandom_range(3) == 0)
            w[31:25] = $urandom_range(1) ? 7'h20 : 7'h00;
        return w;
    endfunction

    function automatic logic [31:0] random_comp();
        logic [31:0] w;
        w = $urandom();
        w[1:0] = 2'($urandom_range(2));
        if ($urandom_range(4) == 0)
            w[6:2] = 5'd0;
        return w;
    endfunction

    task automatic fill_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n)
            word_queue.push_back($urandom_range(1) ? random_base() : random_comp());
        wait (word_queue.size() == 0 && !in_valid && decode_queue.size() == 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes and special forms
        word_queue.push_back(32'h0000_0000);   // compressed all zero, unknown
        word_queue.push_back(32'hFFFF_FFFF);   // base all ones
        word_queue.push_back(32'h4000_5033);   // SRA
        word_queue.push_back(32'h4000_0033);   // SUB
        word_queue.push_back(32'h4000_5013);   // SRAI
        word_queue.push_back(32'h0000_5013);   // SRLI
        word_queue.push_back(32'h8000_0063);   // BEQ negative
        word_queue.push_back(32'h8000_006F);   // JAL negative
        word_queue.push_back(32'hFFFF_F037);   // LUI
        word_queue.push_back(32'h0000_3003);   // load funct3 3, unknown
        word_queue.push_back(32'h0000_2063);   // branch funct3 2, unknown
        word_queue.push_back(32'h0000_3023);   // store funct3 3, unknown
        word_queue.push_back(32'hFFFF_0001);   // C.NOP
        word_queue.push_back(32'h0000_7101);   // C.LUI rd 2
        word_queue.push_back(32'h0000_8002);   // C.JR x0
        word_queue.push_back(32'h0000_9002);   // C.JALR x0 form
        word_queue.push_back(32'h0000_8086);   // C.MV
        word_queue.push_back(32'h0000_9086);   // C.ADD
        word_queue.push_back(32'h0000_9C7D);   // arith group, bit 12 set
        word_queue.push_back(32'h0000_F07D);   // C.BNEZ negative
        word_queue.push_back(32'h0000_C001);   // C.BEQZ
        word_queue.push_back(32'h0000_3FFD);   // C.JAL negative
        word_queue.push_back(32'h0000_FFFC);   // compressed quadrant 0 funct3 7, unknown
        word_queue.push_back(32'h0000_FFFE);   // compressed quadrant 2 funct3 7, unknown
        word_queue.push_back(32'h0000_0000);
        wait (word_queue.size() == 0 && !in_valid && decode_queue.size() == 0);

        fill_phase(400, 0, 0);
        fill_phase(350, 76, 0);
        fill_phase(350, 0, 76);
        fill_phase(450, 17, 17);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
